FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DSCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DSCT_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dsct_pkg.sv
// ----------------------------------------------------------------------------
// dsct_pkg
// Types, codes and fixed widths of the moving-average crossover trader.
// ----------------------------------------------------------------------------
package dsct_pkg;

   localparam int PRICE_W   = 24;
   localparam int MONEY_W   = 48;
   localparam int TALLY_W   = 16;
   localparam int RET_W     = 32;
   localparam int WIN_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int DVD_W     = 64;
   localparam int DIV_CNT_W = 7;

   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd64;
   localparam logic [MONEY_W-1:0]   MONEY_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [RET_W-1:0]     RET_MAX   = 32'h7FFF_FFFF;
   localparam logic [TALLY_W-1:0]   TALLY_MAX = 16'hFFFF;

   localparam logic [WIN_W-1:0]   SHORT_RST = 7'd5;
   localparam logic [WIN_W-1:0]   LONG_RST  = 7'd20;
   localparam logic [MONEY_W-1:0] CASH_RST  = 48'd1000000;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CASH  = 2'd2;

   typedef enum logic [1:0] {
      KIND_BUY   = 2'd0,
      KIND_SELL  = 2'd1,
      KIND_FINAL = 2'd2,
      KIND_SUM   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REL_EQUAL = 2'd0,
      REL_ABOVE = 2'd1,
      REL_BELOW = 2'd2
   } rel_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_S, ST_RD_L, ST_UPD, ST_MUL, ST_CMP,
      ST_BUY_DIV, ST_BUY_WAIT, ST_EMIT_BUY, ST_FIN_CHK,
      ST_SELL_LO, ST_SELL_HI, ST_SELL_SAT, ST_SELL_ADD, ST_EMIT_SELL,
      ST_RET_PREP, ST_RET_DIV, ST_RET_WAIT, ST_EMIT_SUM
   } state_type;

   typedef struct packed {
      logic     load_in;
      logic     rd_long;
      logic     cap_old_s;
      logic     upd_sums;
      logic     do_mul;
      logic     do_cmp;
      logic     buy_zero;
      logic     div_buy;
      logic     buy_done;
      logic     mul_lo;
      logic     mul_hi;
      logic     sat_prod;
      logic     add_cash;
      logic     ret_prep;
      logic     div_ret;
      logic     ret_fin;
      logic     emit;
      kind_type emit_kind;
      logic     emit_last;
      logic     clr_shares;
      logic     rearm;
   } dp_cmd_type;

   typedef struct packed {
      logic buy_go;
      logic sell_go;
      logic last_day;
      logic price_zero;
      logic have_shares;
      logic init_zero;
      logic div_done;
      logic out_free;
   } dp_sts_type;

endpackage

FILE: hw/rtl/dsct_ifs.sv
// ----------------------------------------------------------------------------
// dsct channel interfaces
// Price request, trade result and register write channels.
// ----------------------------------------------------------------------------
interface dsct_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] price;
   logic        in_window;
   logic        last_day;
   modport source (output valid, price, in_window, last_day, input ready);
   modport sink   (input valid, price, in_window, last_day, output ready);
endinterface

interface dsct_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [23:0] trade_price;
   logic [47:0] share_count;
   logic [47:0] cash_after;
   logic [15:0] trades_done;
   logic signed [31:0] return_hundredths;
   logic        last;
   modport source (output valid, kind, trade_price, share_count, cash_after,
                   trades_done, return_hundredths, last, input ready);
   modport sink   (input valid, kind, trade_price, share_count, cash_after,
                   trades_done, return_hundredths, last, output ready);
endinterface

interface dsct_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dsct_ram.sv
// ----------------------------------------------------------------------------
// dsct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsct_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hw/rtl/dsct_div.sv
// ----------------------------------------------------------------------------
// dsct_div
// Restoring divider, one quotient bit per cycle, 64 steps.
// ----------------------------------------------------------------------------
module dsct_div
   import dsct_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DVD_W-1:0]   dividend,
   input  logic [MONEY_W-1:0] divisor,
   output logic               done,
   output logic [DVD_W-1:0]   quotient,
   output logic [MONEY_W-1:0] remainder
);
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;
   logic [DVD_W-1:0]     q_ff;
   logic [MONEY_W-1:0]   r_ff;
   logic [MONEY_W-1:0]   d_ff;
   logic [MONEY_W:0]     trial_in;
   logic                 fits_in;

   always_comb begin
      trial_in = {r_ff, q_ff[DVD_W-1]};
      fits_in  = trial_in >= {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= DIV_STEPS;
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (cnt_ff != '0) begin
         q_ff <= {q_ff[DVD_W-2:0], fits_in};
         r_ff <= fits_in ? MONEY_W'(trial_in - {1'b0, d_ff}) : trial_in[MONEY_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;
endmodule

FILE: hw/rtl/dsct_datapath.sv
// ----------------------------------------------------------------------------
// dsct_datapath
// Price ring, running sums, cross detection, portfolio and result register.
// ----------------------------------------------------------------------------
module dsct_datapath
   import dsct_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   input  logic [PRICE_W-1:0]   in_price,
   input  logic                 in_window,
   input  logic                 in_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [MONEY_W-1:0]   csr_data,
   dsct_rsp_if.source           rsp_bus
);
   localparam int PTR_W  = $clog2(MAX_WINDOW);
   localparam int SEEN_W = $clog2(MAX_WINDOW + 2);
   localparam int SUM_W  = PRICE_W + $clog2(MAX_WINDOW + 1);
   localparam int PROD_W = SUM_W + WIN_W;

   // configuration
   logic [WIN_W-1:0]   short_win_ff, long_win_ff;
   logic [MONEY_W-1:0] init_cash_ff;
   // current beat
   logic [PRICE_W-1:0] price_ff;
   logic               inw_ff, last_ff;
   // series state
   logic [PTR_W-1:0]   ptr_ff;
   logic [SEEN_W-1:0]  seen_ff;
   logic [SUM_W-1:0]   ssum_ff, lsum_ff;
   logic [PRICE_W-1:0] old_s_ff;
   logic [PROD_W-1:0]  prod_a_ff, prod_b_ff;
   rel_type            prev_ff;
   logic               started_ff;
   logic [MONEY_W-1:0] cash_ff, shares_ff;
   logic [TALLY_W-1:0] tally_ff;
   logic [MONEY_W-1:0] mlo_ff, mhi_ff, msat_ff;
   logic               up_ff;
   logic [RET_W-1:0]   ret_ff;
   logic [DVD_W-1:0]   dvd_ff;
   // result register
   logic               rsp_valid_ff;
   kind_type           rsp_kind_ff;
   logic [PRICE_W-1:0] rsp_price_ff;
   logic [MONEY_W-1:0] rsp_shares_ff, rsp_cash_ff;
   logic [TALLY_W-1:0] rsp_tally_ff;
   logic [RET_W-1:0]   rsp_ret_ff;
   logic               rsp_last_ff;

   logic [WIN_W-1:0]   sw, lw, mw;
   logic [PTR_W-1:0]   idx_s, idx_l, raddr;
   logic [PRICE_W-1:0] rdata;
   logic [SUM_W-1:0]   ssum_in, lsum_in;
   rel_type            rel;
   logic               eval_ok, trade_ok, buy_go, sell_go;
   logic [MONEY_W-1:0] mul_p;
   logic [MONEY_W:0]   prod_sum, cash_sum;
   logic [MONEY_W-1:0] diff;
   logic               rearm, cfg_hit, div_done;
   logic [DVD_W-1:0]   div_q;
   logic [MONEY_W-1:0] div_r;
   logic [TALLY_W-1:0] tally_inc;

   always_comb begin
      sw = (short_win_ff == '0) ? WIN_W'(1) :
           (32'(short_win_ff) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : short_win_ff;
      lw = (long_win_ff == '0) ? WIN_W'(1) :
           (32'(long_win_ff) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : long_win_ff;
      mw = (sw > lw) ? sw : lw;
   end

   // ring slots that drop out of each window
   always_comb begin
      int ds, dl;
      ds = int'(ptr_ff) - int'(sw);
      dl = int'(ptr_ff) - int'(lw);
      if (ds < 0) ds = ds + MAX_WINDOW;
      if (dl < 0) dl = dl + MAX_WINDOW;
      idx_s = PTR_W'(ds);
      idx_l = PTR_W'(dl);
      raddr = cmd.rd_long ? idx_l : idx_s;
   end

   dsct_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_WINDOW)) u_ring (
      .clock (clock),
      .we    (cmd.upd_sums),
      .waddr (ptr_ff),
      .wdata (price_ff),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      ssum_in = ssum_ff + SUM_W'(price_ff);
      lsum_in = lsum_ff + SUM_W'(price_ff);
      if (32'(seen_ff) >= 32'(sw)) ssum_in = ssum_in - SUM_W'(old_s_ff);
      if (32'(seen_ff) >= 32'(lw)) lsum_in = lsum_in - SUM_W'(rdata);
   end

   always_comb begin
      rel      = (prod_a_ff > prod_b_ff) ? REL_ABOVE :
                 (prod_a_ff < prod_b_ff) ? REL_BELOW : REL_EQUAL;
      eval_ok  = 32'(seen_ff) >= 32'(mw);
      trade_ok = eval_ok && (32'(seen_ff) >= 32'(mw) + 1) && inw_ff && started_ff;
      buy_go   = trade_ok && prev_ff != REL_ABOVE && rel == REL_ABOVE &&
                 shares_ff == '0;
      sell_go  = trade_ok && !buy_go && prev_ff != REL_BELOW && rel == REL_BELOW &&
                 shares_ff != '0;
   end

   // shared 24x24 multiplier, low then high half of the holding
   assign mul_p = MONEY_W'(cmd.mul_hi ? shares_ff[MONEY_W-1:PRICE_W]
                                      : shares_ff[PRICE_W-1:0]) * MONEY_W'(price_ff);
   assign prod_sum = {1'b0, mhi_ff[PRICE_W-1:0], {PRICE_W{1'b0}}} + {1'b0, mlo_ff};
   assign cash_sum = {1'b0, cash_ff} + {1'b0, msat_ff};
   assign diff = (cash_ff >= init_cash_ff) ? cash_ff - init_cash_ff
                                           : init_cash_ff - cash_ff;
   assign tally_inc = (tally_ff == TALLY_MAX) ? tally_ff : tally_ff + 1'b1;

   dsct_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_buy || cmd.div_ret),
      .dividend  (cmd.div_ret ? dvd_ff : DVD_W'(cash_ff)),
      .divisor   (cmd.div_ret ? init_cash_ff : MONEY_W'(price_ff)),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign cfg_hit = csr_we && csr_idx <= CSR_CASH;
   assign rearm   = cmd.rearm || cfg_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_win_ff <= SHORT_RST;
         long_win_ff  <= LONG_RST;
         init_cash_ff <= CASH_RST;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_SHORT: short_win_ff <= csr_data[WIN_W-1:0];
            CSR_LONG:  long_win_ff  <= csr_data[WIN_W-1:0];
            CSR_CASH:  init_cash_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         seen_ff    <= '0;
         ssum_ff    <= '0;
         lsum_ff    <= '0;
         prev_ff    <= REL_EQUAL;
         started_ff <= 1'b0;
         cash_ff    <= CASH_RST;
         shares_ff  <= '0;
         tally_ff   <= '0;
      end else if (rearm) begin
         ptr_ff     <= '0;
         seen_ff    <= '0;
         ssum_ff    <= '0;
         lsum_ff    <= '0;
         prev_ff    <= REL_EQUAL;
         started_ff <= 1'b0;
         cash_ff    <= (cfg_hit && csr_idx == CSR_CASH) ? csr_data : init_cash_ff;
         shares_ff  <= '0;
         tally_ff   <= '0;
      end else begin
         if (cmd.upd_sums) begin
            ssum_ff <= ssum_in;
            lsum_ff <= lsum_in;
            ptr_ff  <= (32'(ptr_ff) == MAX_WINDOW - 1) ? '0 : ptr_ff + 1'b1;
            if (32'(seen_ff) <= MAX_WINDOW) seen_ff <= seen_ff + 1'b1;
         end
         if (cmd.do_cmp) begin
            if (eval_ok) prev_ff <= rel;
            if (inw_ff) started_ff <= 1'b1;
         end
         if (cmd.buy_zero) begin
            shares_ff <= '0;
            tally_ff  <= tally_inc;
         end
         if (cmd.buy_done) begin
            shares_ff <= div_q[MONEY_W-1:0];
            cash_ff   <= div_r;
            tally_ff  <= tally_inc;
         end
         if (cmd.add_cash) begin
            cash_ff  <= cash_sum[MONEY_W] ? MONEY_MAX : cash_sum[MONEY_W-1:0];
            tally_ff <= tally_inc;
         end
         if (cmd.clr_shares) shares_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         price_ff <= in_price;
         inw_ff   <= in_window;
         last_ff  <= in_last;
      end
      if (cmd.cap_old_s) old_s_ff <= rdata;
      if (cmd.do_mul) begin
         prod_a_ff <= PROD_W'(ssum_ff) * PROD_W'(lw);
         prod_b_ff <= PROD_W'(lsum_ff) * PROD_W'(sw);
      end
      if (cmd.mul_lo) mlo_ff <= mul_p;
      if (cmd.mul_hi) mhi_ff <= mul_p;
      if (cmd.sat_prod) begin
         msat_ff <= (mhi_ff[MONEY_W-1:PRICE_W] != '0 || prod_sum[MONEY_W]) ?
                    MONEY_MAX : prod_sum[MONEY_W-1:0];
      end
      if (cmd.ret_prep) begin
         up_ff  <= cash_ff >= init_cash_ff;
         ret_ff <= '0;
         // times 10000 = 8192 + 1024 + 512 + 256 + 16
         dvd_ff <= (DVD_W'(diff) << 13) + (DVD_W'(diff) << 10) + (DVD_W'(diff) << 9) +
                   (DVD_W'(diff) << 8) + (DVD_W'(diff) << 4);
      end
      if (cmd.ret_fin) begin
         if (up_ff) ret_ff <= (div_q > DVD_W'(RET_MAX)) ? RET_MAX : div_q[RET_W-1:0];
         else       ret_ff <= RET_W'(0) - div_q[RET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff   <= cmd.emit_kind;
         rsp_price_ff  <= (cmd.emit_kind == KIND_SUM) ? '0 : price_ff;
         rsp_shares_ff <= (cmd.emit_kind == KIND_SUM) ? '0 : shares_ff;
         rsp_cash_ff   <= cash_ff;
         rsp_tally_ff  <= tally_ff;
         rsp_ret_ff    <= (cmd.emit_kind == KIND_SUM) ? ret_ff : '0;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.kind              = rsp_kind_ff;
   assign rsp_bus.trade_price       = rsp_price_ff;
   assign rsp_bus.share_count       = rsp_shares_ff;
   assign rsp_bus.cash_after        = rsp_cash_ff;
   assign rsp_bus.trades_done       = rsp_tally_ff;
   assign rsp_bus.return_hundredths = rsp_ret_ff;
   assign rsp_bus.last              = rsp_last_ff;

   always_comb begin
      sts.buy_go      = buy_go;
      sts.sell_go     = sell_go;
      sts.last_day    = last_ff;
      sts.price_zero  = price_ff == '0;
      sts.have_shares = shares_ff != '0;
      sts.init_zero   = init_cash_ff == '0;
      sts.div_done    = div_done;
      sts.out_free    = !rsp_valid_ff || rsp_bus.ready;
   end
endmodule

FILE: hw/rtl/dsct_ctrl.sv
// ----------------------------------------------------------------------------
// dsct_ctrl
// Sequencer: ring reads, sum update, cross check, trades and summary.
// ----------------------------------------------------------------------------
module dsct_ctrl
   import dsct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);
   state_type state_ff, state_in;
   logic      final_ff, final_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      unique case (state_ff)
         ST_IDLE:     if (in_valid) state_in = ST_RD_S;
         ST_RD_S:     state_in = ST_RD_L;
         ST_RD_L:     state_in = ST_UPD;
         ST_UPD:      state_in = ST_MUL;
         ST_MUL:      state_in = ST_CMP;
         ST_CMP: begin
            priority if (sts.buy_go) begin
               state_in = sts.price_zero ? ST_EMIT_BUY : ST_BUY_DIV;
            end else if (sts.sell_go) begin
               state_in = ST_SELL_LO;
               final_in = 1'b0;
            end else begin
               state_in = sts.last_day ? ST_FIN_CHK : ST_IDLE;
            end
         end
         ST_BUY_DIV:  state_in = ST_BUY_WAIT;
         ST_BUY_WAIT: if (sts.div_done) state_in = ST_EMIT_BUY;
         ST_EMIT_BUY: begin
            if (sts.out_free) state_in = sts.last_day ? ST_FIN_CHK : ST_IDLE;
         end
         ST_FIN_CHK: begin
            if (sts.have_shares) begin
               state_in = ST_SELL_LO;
               final_in = 1'b1;
            end else begin
               state_in = ST_RET_PREP;
            end
         end
         ST_SELL_LO:  state_in = ST_SELL_HI;
         ST_SELL_HI:  state_in = ST_SELL_SAT;
         ST_SELL_SAT: state_in = ST_SELL_ADD;
         ST_SELL_ADD: state_in = ST_EMIT_SELL;
         ST_EMIT_SELL: begin
            if (sts.out_free) begin
               state_in = final_ff ? ST_RET_PREP : (sts.last_day ? ST_FIN_CHK : ST_IDLE);
            end
         end
         ST_RET_PREP: state_in = sts.init_zero ? ST_EMIT_SUM : ST_RET_DIV;
         ST_RET_DIV:  state_in = ST_RET_WAIT;
         ST_RET_WAIT: if (sts.div_done) state_in = ST_EMIT_SUM;
         ST_EMIT_SUM: if (sts.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.emit_kind = KIND_BUY;
      in_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.load_in = in_valid;
         end
         ST_RD_S: ;
         ST_RD_L: begin
            cmd.rd_long   = 1'b1;
            cmd.cap_old_s = 1'b1;
         end
         ST_UPD:      cmd.upd_sums = 1'b1;
         ST_MUL:      cmd.do_mul   = 1'b1;
         ST_CMP: begin
            cmd.do_cmp   = 1'b1;
            cmd.buy_zero = sts.buy_go && sts.price_zero;
         end
         ST_BUY_DIV:  cmd.div_buy  = 1'b1;
         ST_BUY_WAIT: cmd.buy_done = sts.div_done;
         ST_EMIT_BUY: begin
            cmd.emit      = sts.out_free;
            cmd.emit_kind = KIND_BUY;
            cmd.emit_last = !sts.last_day;
         end
         ST_FIN_CHK: ;
         ST_SELL_LO:  cmd.mul_lo   = 1'b1;
         ST_SELL_HI:  cmd.mul_hi   = 1'b1;
         ST_SELL_SAT: cmd.sat_prod = 1'b1;
         ST_SELL_ADD: cmd.add_cash = 1'b1;
         ST_EMIT_SELL: begin
            cmd.emit       = sts.out_free;
            cmd.clr_shares = sts.out_free;
            cmd.emit_kind  = final_ff ? KIND_FINAL : KIND_SELL;
            cmd.emit_last  = !final_ff && !sts.last_day;
         end
         ST_RET_PREP: cmd.ret_prep = 1'b1;
         ST_RET_DIV:  cmd.div_ret  = 1'b1;
         ST_RET_WAIT: cmd.ret_fin  = sts.div_done;
         ST_EMIT_SUM: begin
            cmd.emit      = sts.out_free;
            cmd.rearm     = sts.out_free;
            cmd.emit_kind = KIND_SUM;
            cmd.emit_last = 1'b1;
         end
         default: ;
      endcase
   end
endmodule

FILE: hw/rtl/dual_sma_crossover_trader.sv
// ----------------------------------------------------------------------------
// dual_sma_crossover_trader
// Short/long moving-average crossover trader with a final settlement summary.
// ----------------------------------------------------------------------------
// req_bus carries one closing price per beat with its in_window and last_day
// flags; rsp_bus returns zero to three results per price (buy, sell on cross,
// final forced sale, summary), the last one flagged by last. csr_bus writes
// short_window (0), long_window (1) and initial_cash (2); a write to any of
// these re-arms the series. Write registers only while the block is idle.
// From accept to the cross decision a price passes two reads of the ring
// RAM, the sum update, the cross-products and the compare. A buy adds the
// 64-step divider (skipped at a zero price), a sale the split 24x24 multiply
// and the saturating adds, the summary the return division (skipped at zero
// initial cash). One price is in work at a time. Reset clears the series
// state and loads the register defaults (5, 20, 1000000 cents); no clearing
// pass is needed. Results leave through an output register: a stalled
// receiver holds the sequencer at its next result, while a new price may be
// taken as soon as the last result is in that register.
module dual_sma_crossover_trader
   import dsct_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input logic        clock,
   input logic        reset,
   dsct_req_if.sink   req_bus,
   dsct_rsp_if.source rsp_bus,
   dsct_csr_if.sink   csr_bus
);
`include "assert_macros.svh"

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       in_ready;

   assign req_bus.ready = in_ready;
   assign csr_bus.ready = 1'b1;

   dsct_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (in_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   dsct_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_price  (req_bus.price),
      .in_window (req_bus.in_window),
      .in_last   (req_bus.last_day),
      .csr_we    (csr_bus.valid),
      .csr_idx   (csr_bus.index),
      .csr_data  (csr_bus.data),
      .rsp_bus   (rsp_bus)
   );

   `DSCT_ASSERT(a_emit_has_room, clock, reset, (cmd.emit |-> sts.out_free), "result overwritten")
   `DSCT_ASSERT(a_no_emit_on_accept, clock, reset, ((req_bus.valid && req_bus.ready) |-> !cmd.emit), "emit while accepting")
   `DSCT_ASSERT(a_sum_is_last, clock, reset, ((rsp_bus.valid && rsp_bus.kind == KIND_SUM) |-> rsp_bus.last), "summary not last")
   `DSCT_ASSERT_NR(a_reset_clears_rsp, clock, (reset |=> !rsp_bus.valid), "result valid after reset")
endmodule

FILE: tb/dsct_tb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsct testbench interface notes
// Channel interfaces come from the RTL; this file holds the shared beat type.
// ----------------------------------------------------------------------------
package dsct_tb_pkg;
   import dsct_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [23:0] trade_price;
      logic [47:0] share_count;
      logic [47:0] cash_after;
      logic [15:0] trades_done;
      logic [31:0] return_hundredths;
      logic        last;
   } trade_beat_type;
endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Crossover trader check: directed and random price series against a
// behavioral trading model, with random idling and a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
   import dsct_pkg::*;
   import dsct_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   dsct_req_if req_bus();
   dsct_rsp_if rsp_bus();
   dsct_csr_if csr_bus();

   dual_sma_crossover_trader u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // model state
   logic [6:0]  cfg_short = SHORT_RST;
   logic [6:0]  cfg_long  = LONG_RST;
   logic [47:0] cfg_cash  = CASH_RST;
   logic [23:0] ring [64];
   int unsigned wr_ptr, seen;
   logic [63:0] sum_s, sum_l;
   rel_type     prev_rel;
   bit          started;
   logic [63:0] cash, shares;
   int unsigned tally;

   trade_beat_type expected_trades[$];
   int             fail_count = 0;
   int             stall_hold = 0;
   int             rsp_wait   = 0;

   task automatic rearm_series();
      wr_ptr = 0; seen = 0; sum_s = 0; sum_l = 0; prev_rel = REL_EQUAL;
      started = 0; cash = cfg_cash; shares = 0; tally = 0;
   endtask

   function automatic int unsigned clamp_win(logic [6:0] w);
      if (w == 0) return 1;
      if (w > 64) return 64;
      return w;
   endfunction

   function automatic logic [63:0] sat_money(logic [63:0] a, logic [63:0] b, bit mul);
      logic [127:0] r;
      r = mul ? a * b : a + b;
      return (r > 128'(MONEY_MAX)) ? 64'(MONEY_MAX) : r[63:0];
   endfunction

   task automatic push_trade(kind_type k, logic [63:0] p, logic [63:0] sh,
                             logic [63:0] c, logic [31:0] ret);
      trade_beat_type t;
      t.kind = k; t.trade_price = p[23:0]; t.share_count = sh[47:0];
      t.cash_after = c[47:0]; t.trades_done = tally[15:0];
      t.return_hundredths = ret; t.last = 1'b0;
      expected_trades.insert(expected_trades.size(), t);
   endtask

   task automatic predict_trades(logic [23:0] price, bit inw, bit lastd);
      int unsigned sw, lw, mw, n0;
      logic [63:0] a, b, q;
      rel_type rel;
      sw = clamp_win(cfg_short); lw = clamp_win(cfg_long);
      mw = sw > lw ? sw : lw;
      n0 = expected_trades.size();
      sum_s += price; sum_l += price;
      if (seen >= sw) sum_s -= ring[(wr_ptr + 64 - sw) % 64];
      if (seen >= lw) sum_l -= ring[(wr_ptr + 64 - lw) % 64];
      ring[wr_ptr] = price;
      wr_ptr = (wr_ptr + 1) % 64;
      if (seen <= 64) seen++;
      if (seen >= mw) begin
         a = sum_s * lw; b = sum_l * sw;
         rel = a > b ? REL_ABOVE : (a < b ? REL_BELOW : REL_EQUAL);
         if (seen >= mw + 1 && inw && started) begin
            if (prev_rel != REL_ABOVE && rel == REL_ABOVE && shares == 0) begin
               q = price ? cash / price : 0;
               cash -= q * price; shares = q;
               if (tally < 16'hFFFF) tally++;
               push_trade(KIND_BUY, 64'(price), q, cash, 32'd0);
            end else if (prev_rel != REL_BELOW && rel == REL_BELOW && shares > 0) begin
               cash = sat_money(cash, sat_money(shares, 64'(price), 1'b1), 1'b0);
               if (tally < 16'hFFFF) tally++;
               push_trade(KIND_SELL, 64'(price), shares, cash, 32'd0);
               shares = 0;
            end
         end
         prev_rel = rel;
      end
      if (inw) started = 1;
      if (lastd) begin
         if (shares > 0) begin
            cash = sat_money(cash, sat_money(shares, 64'(price), 1'b1), 1'b0);
            if (tally < 16'hFFFF) tally++;
            push_trade(KIND_FINAL, 64'(price), shares, cash, 32'd0);
            shares = 0;
         end
         if (cfg_cash == 0) q = 0;
         else if (cash >= cfg_cash) begin
            q = 64'((128'(cash - cfg_cash) * 10000) / cfg_cash);
            if (q > 64'(RET_MAX)) q = 64'(RET_MAX);
         end else
            q = 64'h1_0000_0000 - 64'((128'(cfg_cash - cash) * 10000) / cfg_cash);
         push_trade(KIND_SUM, 64'd0, 64'd0, cash, q[31:0]);
         rearm_series();
      end
      if (expected_trades.size() > n0)
         expected_trades[expected_trades.size() - 1].last = 1'b1;
   endtask

   initial begin
      req_bus.valid = 0; req_bus.price = 0; req_bus.in_window = 0; req_bus.last_day = 0;
      csr_bus.valid = 0; csr_bus.index = 0; csr_bus.data = 0;
      rsp_bus.ready = 0;
   end

   // receiver: random wait per beat, plus a long hold-off on request
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait <= $urandom_range(0, 10);
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         draw = $urandom_range(0, 10);
         rsp_wait <= draw;
         rsp_bus.ready <= (draw == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_bus.ready <= (rsp_wait == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      trade_beat_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_trades.size() == 0) begin
            $error("unexpected result beat kind=%0d", rsp_bus.kind);
            fail_count++;
         end else begin
            e = expected_trades.pop_front();
            if (rsp_bus.kind !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_bus.kind); fail_count++;
            end
            if (rsp_bus.trade_price !== e.trade_price) begin
               $error("trade_price exp %0d got %0d", e.trade_price, rsp_bus.trade_price);
               fail_count++;
            end
            if (rsp_bus.share_count !== e.share_count) begin
               $error("share_count exp %0d got %0d", e.share_count, rsp_bus.share_count);
               fail_count++;
            end
            if (rsp_bus.cash_after !== e.cash_after) begin
               $error("cash_after exp %0d got %0d", e.cash_after, rsp_bus.cash_after);
               fail_count++;
            end
            if (rsp_bus.trades_done !== e.trades_done) begin
               $error("trades_done exp %0d got %0d", e.trades_done, rsp_bus.trades_done);
               fail_count++;
            end
            if (rsp_bus.return_hundredths !== e.return_hundredths) begin
               $error("return_hundredths exp %0d got %0d", $signed(e.return_hundredths),
                      rsp_bus.return_hundredths);
               fail_count++;
            end
            if (rsp_bus.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_bus.last); fail_count++;
            end
         end
      end
   end

   // valid stays high into the next beat when there is no gap
   task automatic send_price(logic [23:0] price, bit inw, bit lastd);
      int gap;
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1; req_bus.price <= price;
      req_bus.in_window <= inw; req_bus.last_day <= lastd;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_trades(price, inw, lastd);
   endtask

   task automatic drain_trades();
      req_bus.valid <= 1'b0;
      while (expected_trades.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [47:0] val);
      csr_bus.valid <= 1'b1; csr_bus.index <= idx; csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_SHORT) cfg_short = val[6:0];
      else if (idx == CSR_LONG) cfg_long = val[6:0];
      else if (idx == CSR_CASH) cfg_cash = val;
      else return;
      rearm_series();
   endtask

   task automatic configure(logic [6:0] s, logic [6:0] l, logic [47:0] c);
      drain_trades();
      write_reg(CSR_SHORT, 48'(s)); write_reg(CSR_LONG, 48'(l)); write_reg(CSR_CASH, c);
      csr_bus.valid <= 1'b0;
   endtask

   // up, down, up to a final day, crossing both ways; then clamped windows
   task automatic test_directed();
      configure(7'd2, 7'd3, 48'd1000);
      send_price(24'hFFFFFF, 1'b0, 1'b0);
      send_price(24'd1, 1'b0, 1'b0);
      send_price(24'd100, 1'b1, 1'b0);
      send_price(24'd200, 1'b1, 1'b0);
      send_price(24'd300, 1'b1, 1'b0);
      send_price(24'd100, 1'b0, 1'b0);
      send_price(24'd50, 1'b1, 1'b0);
      send_price(24'd20, 1'b1, 1'b0);
      send_price(24'd40, 1'b1, 1'b0);
      send_price(24'd2000, 1'b1, 1'b0);   // buy with cash below price
      send_price(24'd3000, 1'b1, 1'b1);
      configure(7'd1, 7'd64, 48'hFFFF_FFFF_FFFF);
      for (int i = 0; i < 64; i++) send_price(24'(1 + i), i > 60, 1'b0);
      send_price(24'hFFFFFF, 1'b1, 1'b0);
      send_price(24'd1, 1'b1, 1'b1);
      configure(7'd0, 7'd100, 48'd0);
      for (int i = 0; i < 6; i++) send_price(24'($urandom_range(1, 50)), 1'b1, i == 5);
   endtask

   task automatic test_random_series();
      int unsigned len, warm, base, step;
      for (int s = 0; s < 6; s++) begin
         if (s % 4 == 0)
            configure(7'($urandom_range(1, 6)), 7'($urandom_range(1, 8)),
                      s == 4 ? (48'($urandom()) << 16) | 48'($urandom_range(0, 65535))
                             : 48'($urandom_range(1000, 5000000)));
         len = $urandom_range(6, 16);
         warm = $urandom_range(1, 6);
         base = $urandom_range(100, 10000);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) base = $urandom_range(1, 24'hFFFFFF);
            else begin
               step = $urandom_range(0, 400);
               if (base + step <= 200) base = 1;
               else base = base + step - 200;
               if (base > 24'hFFFFFF) base = 24'hFFFFFF;
            end
            send_price(24'(base), i >= warm || $urandom_range(0, 9) == 0,
                       i == len - 1);
         end
      end
   endtask

   task automatic test_backpressure();
      configure(7'd1, 7'd2, 48'd100000);
      stall_hold = 400;
      for (int i = 0; i < 12; i++)
         send_price(24'(i % 2 ? 500 : 100), 1'b1, i == 11);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      rearm_series();
      test_directed();
      test_random_series();
      test_backpressure();
      drain_trades();
      if (fail_count == 0) $display("dual_sma_crossover_trader verification clean");
      else $display("dual_sma_crossover_trader verification failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("dual_sma_crossover_trader verification failed");
      $finish;
   end
endmodule
